### hdl/lru_prefer_clean_replacement_unit_assert.svh
// Assertion macros for the replacement unit
`ifndef LRU_PREFER_CLEAN_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PREFER_CLEAN_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LPCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lpcr_pkg.sv
// Types and constants of the replacement unit
package lpcr_pkg;

    localparam int SETS   = 64;
    localparam int WAYS   = 4;
    localparam int SET_W  = 6;
    localparam int WAY_W  = 2;
    localparam int RANK_W = 2;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_EVICT  = 1'b1
    } t_cmd;

    typedef logic [WAY_W-1:0] t_way;
    typedef logic [SET_W-1:0] t_set;

    // one set: valid, dirty and recency rank for every way (rank 0 most recent)
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             dirty;
        logic [WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

endpackage

### hdl/lru_prefer_clean_replacement_unit.sv
// LRU replacement unit with prefer-clean victim selection
// Result: a victim request reads its set row into stage 1; the chosen way is then registered in r_victim.
// Throughput: one request per cycle while o_in_stall is low (no clearing pass, no blocked victim request
//   in stage 1); per-set state lives in a one-port-read memory, with the row just written bypassed to a
//   following request on the same set. Reset: synchronous, active low; a clearing pass then zeroes all
//   SETS (64) rows of the set memory, during which no request is taken. r_prefer_clean resets to 1.
module lru_prefer_clean_replacement_unit
    import lpcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic [SET_W-1:0] i_set_index,
    input  logic [WAY_W-1:0] i_way,
    input  logic             i_dirty,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [WAY_W-1:0] o_victim_way
);

    `include "lru_prefer_clean_replacement_unit_assert.svh"

    t_row r_mem [SETS];
    t_row r_row;
    t_row n_row;

    logic r_prefer_clean;
    logic r_clearing;
    t_set r_clr_idx;

    logic r_s1_valid;
    t_cmd r_s1_cmd;
    t_set r_s1_set;
    t_way r_s1_way;
    logic r_s1_dirty;

    logic r_out_valid;
    t_way r_victim;

    logic s1_go;
    logic in_acc;

    logic any_inv;
    t_way first_inv;
    logic c_any;
    t_way c_best;
    logic a_any;
    t_way a_best;
    t_way evict_way;
    t_way victim;
    logic [RANK_W-1:0] vr;

    // stage 1 moves on unless it holds a victim request and the result register is blocked
    assign s1_go      = r_s1_valid && (r_s1_cmd == CMD_ACCESS || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !s1_go);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefer_clean <= 1'b1;
            r_clearing     <= 1'b1;
            r_clr_idx      <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prefer_clean <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
                if (r_clr_idx == SET_W'(SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1_cmd == CMD_EVICT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= t_cmd'(i_cmd);
            r_s1_set   <= i_set_index;
            r_s1_way   <= i_way;
            r_s1_dirty <= i_dirty;
        end
        if (s1_go && r_s1_cmd == CMD_EVICT) begin
            r_victim <= victim;
        end
    end

    // set memory: one write, one registered read with bypass of the row being written
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (s1_go) begin
            r_mem[r_s1_set] <= n_row;
        end
        if (in_acc) begin
            if (s1_go && r_s1_set == i_set_index) begin
                r_row <= n_row;
            end else begin
                r_row <= r_mem[i_set_index];
            end
        end
    end

    always_comb begin
        n_row     = r_row;
        any_inv   = 1'b0;
        first_inv = '0;
        c_any     = 1'b0;
        c_best    = '0;
        a_any     = 1'b0;
        a_best    = '0;

        // lowest invalid way wins
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!r_row.valid[i]) begin
                any_inv   = 1'b1;
                first_inv = WAY_W'(i);
            end
        end

        // oldest clean way, and oldest way overall; ties keep the lower index
        for (int i = 0; i < WAYS; i++) begin
            if (r_row.valid[i] && !r_row.dirty[i]
                && (!c_any || r_row.rank[i] > r_row.rank[c_best])) begin
                c_any  = 1'b1;
                c_best = WAY_W'(i);
            end
            if (r_row.valid[i] && (!a_any || r_row.rank[i] > r_row.rank[a_best])) begin
                a_any  = 1'b1;
                a_best = WAY_W'(i);
            end
        end

        evict_way = (r_prefer_clean && c_any) ? c_best : a_best;
        victim    = any_inv ? first_inv : evict_way;
        vr        = r_row.rank[evict_way];

        if (r_s1_cmd == CMD_ACCESS) begin
            // age every valid way younger than the accessed one, or every valid way if it was invalid
            for (int i = 0; i < WAYS; i++) begin
                if (WAY_W'(i) != r_s1_way && r_row.valid[i]
                    && (!r_row.valid[r_s1_way] || r_row.rank[i] < r_row.rank[r_s1_way])) begin
                    n_row.rank[i] = r_row.rank[i] + RANK_W'(1);
                end
            end
            n_row.valid[r_s1_way] = 1'b1;
            n_row.dirty[r_s1_way] = r_s1_dirty;
            n_row.rank[r_s1_way]  = '0;
        end else if (!any_inv) begin
            // close the gap left by the victim
            for (int i = 0; i < WAYS; i++) begin
                if (WAY_W'(i) != evict_way && r_row.valid[i] && r_row.rank[i] > vr) begin
                    n_row.rank[i] = r_row.rank[i] - RANK_W'(1);
                end
            end
            n_row.valid[evict_way] = 1'b0;
            n_row.dirty[evict_way] = 1'b0;
            n_row.rank[evict_way]  = '0;
        end
    end

    `LPCR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, r_s1_valid && o_in_stall && !r_clearing, r_s1_cmd == CMD_EVICT && r_out_valid && i_out_stall, "stage 1 held without a blocked victim request")
    `LPCR_ASSERT_NOW(a_evict_frees, i_clk, i_rst_n, s1_go && r_s1_cmd == CMD_EVICT && !any_inv, $countones(n_row.valid) == WAYS - 1, "eviction of a full set did not free one way")
    `LPCR_ASSERT_NOW(a_access_fills, i_clk, i_rst_n, s1_go && r_s1_cmd == CMD_ACCESS, $countones(n_row.valid) >= $countones(r_row.valid) && n_row.valid[r_s1_way], "access lost a valid way")
    `LPCR_ASSERT_NEXT(a_clear_len, i_clk, i_rst_n, r_clearing && r_clr_idx != SET_W'(SETS - 1), r_clearing, "clearing pass ended early")

endmodule

### tb/lru_prefer_clean_replacement_unit_tb.sv
// Self-checking testbench for the LRU prefer-clean replacement unit
module lru_prefer_clean_replacement_unit_tb
    import lpcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 29;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_CYCLES  = 200_000;

    typedef struct {
        t_set set_idx;
        t_way victim;
    } t_pending_victim;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_cmd;
    logic [SET_W-1:0] i_set_index;
    logic [WAY_W-1:0] i_way;
    logic             i_dirty;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [WAY_W-1:0] o_victim_way;

    // shadow copy of the per-set replacement state
    bit [WAYS-1:0]   way_valid [SETS];
    bit [WAYS-1:0]   way_dirty [SETS];
    bit [RANK_W-1:0] way_rank  [SETS][WAYS];
    bit              clean_first;

    t_pending_victim expected_victims[$];
    t_pending_victim head;
    t_set            hot_sets [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

    bit steady;
    bit hold_off_req;

    int fail_count;
    int access_count;
    int victim_count;
    int checked_count;
    int invalid_pick_count;
    int all_dirty_count;
    int plain_pick_count;

    lru_prefer_clean_replacement_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_set_index  (i_set_index),
        .i_way        (i_way),
        .i_dirty      (i_dirty),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_victim_way (o_victim_way)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic void clear_shadow();
        for (int s = 0; s < SETS; s++) begin
            way_valid[s] = '0;
            way_dirty[s] = '0;
            for (int w = 0; w < WAYS; w++) way_rank[s][w] = '0;
        end
        clean_first = 1'b1;
    endfunction

    function automatic void track_access(t_set s, t_way w, bit d);
        bit [RANK_W:0] limit;
        limit = way_valid[s][w] ? {1'b0, way_rank[s][w]} : (RANK_W + 1)'(WAYS);
        for (int i = 0; i < WAYS; i++) begin
            if (i != w && way_valid[s][i] && way_rank[s][i] < limit)
                way_rank[s][i] = way_rank[s][i] + 1'b1;
        end
        way_valid[s][w] = 1'b1;
        way_dirty[s][w] = d;
        way_rank[s][w]  = '0;
    endfunction

    function automatic t_way pick_victim(t_set s);
        t_way            victim;
        bit              found;
        bit [RANK_W-1:0] vr;
        // an empty slot wins outright and leaves the set untouched
        for (int i = 0; i < WAYS; i++) begin
            if (!way_valid[s][i]) begin
                invalid_pick_count++;
                return t_way'(i);
            end
        end
        victim = '0;
        found  = 1'b0;
        if (clean_first) begin
            for (int i = 0; i < WAYS; i++) begin
                if (!way_dirty[s][i] && (!found || way_rank[s][i] > way_rank[s][victim])) begin
                    victim = t_way'(i);
                    found  = 1'b1;
                end
            end
            if (!found) all_dirty_count++;
        end else begin
            plain_pick_count++;
        end
        if (!found) begin
            for (int i = 0; i < WAYS; i++) begin
                if (!found || way_rank[s][i] > way_rank[s][victim]) begin
                    victim = t_way'(i);
                    found  = 1'b1;
                end
            end
        end
        vr = way_rank[s][victim];
        for (int i = 0; i < WAYS; i++) begin
            if (i != victim && way_valid[s][i] && way_rank[s][i] > vr)
                way_rank[s][i] = way_rank[s][i] - 1'b1;
        end
        way_valid[s][victim] = 1'b0;
        way_dirty[s][victim] = 1'b0;
        way_rank[s][victim]  = '0;
        return victim;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endfunction

    // compare every delivered victim with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_victims.size() == 0) begin
                note_failure($sformatf("victim %0d delivered with no victim request pending",
                                       o_victim_way));
            end else begin
                head = expected_victims.pop_front();
                checked_count++;
                if (o_victim_way !== head.victim)
                    note_failure($sformatf("set %0d: victim expected %0d, actual %0d",
                                           head.set_idx, head.victim, o_victim_way));
            end
        end
    end

    // result side: random stalls, or a counted hold-off when asked for
    initial begin
        int held;
        held        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                held++;
                if (held == HOLD_OFF_CYCLES) begin
                    held         = 0;
                    hold_off_req = 1'b0;
                end
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_request(input t_cmd c, input t_set s, input t_way w, input logic d);
        t_pending_victim entry;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_set_index <= s;
        i_way       <= w;
        i_dirty     <= d;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (c == CMD_ACCESS) begin
            track_access(s, w, d);
            access_count++;
        end else begin
            entry.set_idx = s;
            entry.victim  = pick_victim(s);
            expected_victims.push_back(entry);
            victim_count++;
        end
        @(negedge i_clk);
    endtask

    // drop valid, let every victim arrive and let trailing accesses settle
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (expected_victims.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_replacement_mode(input bit prefer_clean);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= prefer_clean;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        clean_first  = prefer_clean;
    endtask

    task automatic random_requests(input int count, input int evict_pct);
        t_cmd c;
        t_set s;
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 4) && (n < count / 4 + 80);
            // mostly a few busy sets, so they fill up and evictions get interesting
            s = ($urandom_range(99) < 75) ? hot_sets[$urandom_range(3)]
                                          : t_set'($urandom_range(SETS - 1));
            c = ($urandom_range(99) < evict_pct) ? CMD_EVICT : CMD_ACCESS;
            send_request(c, s, t_way'($urandom_range(WAYS - 1)), 1'($urandom_range(1)));
        end
        steady = 1'b0;
    endtask

    task automatic test_prefer_clean_directed();
        send_request(CMD_EVICT,  6'd0,  2'd0, 1'b0);   // empty set
        send_request(CMD_ACCESS, 6'd63, 2'd3, 1'b1);
        send_request(CMD_EVICT,  6'd63, 2'd3, 1'b1);   // empty slot first
        send_request(CMD_ACCESS, 6'd63, 2'd0, 1'b1);
        send_request(CMD_ACCESS, 6'd63, 2'd1, 1'b0);
        send_request(CMD_ACCESS, 6'd63, 2'd2, 1'b1);
        send_request(CMD_ACCESS, 6'd63, 2'd3, 1'b1);
        send_request(CMD_ACCESS, 6'd63, 2'd1, 1'b0);   // re-touch a valid way
        send_request(CMD_EVICT,  6'd63, 2'd0, 1'b0);   // only clean way goes
        send_request(CMD_ACCESS, 6'd63, 2'd1, 1'b1);
        send_request(CMD_EVICT,  6'd63, 2'd2, 1'b1);   // every way dirty
        send_request(CMD_ACCESS, 6'd63, 2'd3, 1'b0);
        send_request(CMD_EVICT,  6'd63, 2'd1, 1'b0);   // the freed slot wins over the clean way
    endtask

    task automatic test_plain_lru_directed();
        set_replacement_mode(1'b0);
        send_request(CMD_ACCESS, 6'd42, 2'd1, 1'b1);
        send_request(CMD_ACCESS, 6'd42, 2'd0, 1'b0);
        send_request(CMD_ACCESS, 6'd42, 2'd2, 1'b0);
        send_request(CMD_ACCESS, 6'd42, 2'd3, 1'b1);
        send_request(CMD_EVICT,  6'd42, 2'd0, 1'b0);   // oldest is dirty, still taken
        send_request(CMD_EVICT,  6'd42, 2'd3, 1'b1);
        send_request(CMD_ACCESS, 6'd42, 2'd1, 1'b0);
        send_request(CMD_EVICT,  6'd42, 2'd0, 1'b0);
        send_request(CMD_EVICT,  6'd21, 2'd0, 1'b0);
    endtask

    task automatic test_random_prefer_clean();
        set_replacement_mode(1'b1);
        random_requests(450, 30);
    endtask

    task automatic test_random_plain_lru();
        set_replacement_mode(1'b0);
        random_requests(450, 30);
    endtask

    task automatic test_output_backpressure();
        set_replacement_mode(1'b1);
        steady       = 1'b1;
        hold_off_req = 1'b1;
        // keep offering victim requests while results are held back
        for (int n = 0; n < 80; n++)
            send_request(($urandom_range(99) < 70) ? CMD_EVICT : CMD_ACCESS,
                         hot_sets[$urandom_range(3)], t_way'($urandom_range(WAYS - 1)),
                         1'($urandom_range(1)));
        steady = 1'b0;
        while (hold_off_req) @(negedge i_clk);
    endtask

    task automatic test_random_mixed_modes();
        set_replacement_mode(1'b0);
        random_requests(200, 40);
        set_replacement_mode(1'b1);
        random_requests(220, 25);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_ACCESS;
        i_set_index  = '0;
        i_way        = '0;
        i_dirty      = 1'b0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        clear_shadow();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_prefer_clean_directed();
        test_plain_lru_directed();
        test_random_prefer_clean();
        test_random_plain_lru();
        test_output_backpressure();
        test_random_mixed_modes();
        wait_quiet();

        $display("Sent %0d access and %0d victim requests; %0d victims checked.",
                 access_count, victim_count, checked_count);
        $display("Victim paths: %0d empty-slot, %0d all-dirty fallback, %0d plain LRU.",
                 invalid_pick_count, all_dirty_count, plain_pick_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures in total", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d victims outstanding", expected_victims.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
